// ===== src/efd_pkg.sv =====
package efd_pkg;

    localparam int MAX_FRAME_LEN_DEF = 256;

    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_BYTE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE = 2'd2;

    localparam logic [BYTE_W-1:0] START_BYTE_RST  = 8'd1;
    localparam logic [BYTE_W-1:0] END_BYTE_RST    = 8'd4;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd27;

    // frame status codes
    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] escape_byte;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   payload_length;
    } result_t;

    // CRC-16 Modbus, one byte, reflected
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc ^ {8'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== src/escaped_frame_decoder_crc16_core.sv =====
// Byte-stuffed frame deframer with CRC-16 (Modbus) check. Raw bytes enter on
// rx_*; an unescaped start byte opens a frame, an escape byte inside a frame
// makes the next byte literal, an unescaped end byte closes it. Payload bytes
// leave on out_* with frame_end low, delayed by two data bytes so that the last
// two bytes of a frame are kept back as the received CRC (low byte first); the
// close gives one request with frame_end high, the status and the length
// (saturated at 255). Bytes outside a frame are dropped. One byte is taken
// per clock while the result register is free; a byte goes through an input
// register, then the decode and byte-wide CRC update feeding the frame state,
// then the result register. Write the delimiter registers only while idle.
module escaped_frame_decoder_crc16_core
#(
    parameter int MAX_FRAME_LEN = efd_pkg::MAX_FRAME_LEN_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [efd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [efd_pkg::BYTE_W-1:0]       cfg_data,
    input  logic                             rx_valid,
    output logic                             rx_ready,
    input  logic [efd_pkg::BYTE_W-1:0]       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [efd_pkg::BYTE_W-1:0]       payload_byte,
    output logic                             frame_end,
    output logic [efd_pkg::STATUS_W-1:0]     frame_status,
    output logic [efd_pkg::BYTE_W-1:0]       payload_length
);

    efd_pkg::cfg_t              cfg_reg;
    efd_pkg::cfg_t              cfg_next;
    logic                       held_valid;
    logic [efd_pkg::BYTE_W-1:0] held_byte;
    logic                       out_free;
    logic                       advance;
    logic                       res_valid;
    efd_pkg::result_t           res;

    assign advance = held_valid && out_free;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                efd_pkg::REG_START_BYTE:  cfg_next.start_byte  = cfg_data;
                efd_pkg::REG_END_BYTE:    cfg_next.end_byte    = cfg_data;
                efd_pkg::REG_ESCAPE_BYTE: cfg_next.escape_byte = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= efd_pkg::START_BYTE_RST;
            cfg_reg.end_byte    <= efd_pkg::END_BYTE_RST;
            cfg_reg.escape_byte <= efd_pkg::ESCAPE_BYTE_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    efd_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .pop        (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    efd_deframer #(.MAX_FRAME_LEN(MAX_FRAME_LEN)) u_deframer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .step      (advance),
        .data      (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    efd_out_stage u_out
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (res_valid),
        .res            (res),
        .free           (out_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end),
        .frame_status   (frame_status),
        .payload_length (payload_length)
    );

endmodule

// ===== src/efd_in_stage.sv =====
module efd_in_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_ready,
    input  logic [efd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        pop,
    output logic                        held_valid,
    output logic [efd_pkg::BYTE_W-1:0]  held_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [efd_pkg::BYTE_W-1:0] byte_reg;

    assign rx_ready   = !valid_reg || pop;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx_ready)
            valid_next = rx_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
            byte_reg <= rx_byte;
    end

endmodule

// ===== src/efd_deframer.sv =====
module efd_deframer
#(
    parameter int MAX_FRAME_LEN = efd_pkg::MAX_FRAME_LEN_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  efd_pkg::cfg_t               cfg,
    input  logic                        step,
    input  logic [efd_pkg::BYTE_W-1:0]  data,
    output logic                        res_valid,
    output efd_pkg::result_t            res
);

    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int EXT_W = LEN_W + 8;

    logic                       esc_pend_reg, esc_pend_next;
    logic                       inside_reg, inside_next;
    logic [15:0]                crc_reg, crc_next;
    logic [1:0]                 count_reg, count_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       ovf_reg, ovf_next;
    logic [efd_pkg::BYTE_W-1:0] held0_reg, held0_next;
    logic [efd_pkg::BYTE_W-1:0] held1_reg, held1_next;

    logic             is_esc, is_start, is_end;
    logic [LEN_W:0]   fill;
    logic [EXT_W-1:0] len_ext;
    logic [15:0]      rx_crc;

    assign is_esc   = !esc_pend_reg && (data == cfg.escape_byte);
    assign is_start = !esc_pend_reg && !is_esc && (data == cfg.start_byte);
    assign is_end   = !esc_pend_reg && !is_esc && !is_start && (data == cfg.end_byte);
    assign fill     = (LEN_W+1)'(len_reg) + (LEN_W+1)'(count_reg);
    assign len_ext  = EXT_W'(len_reg);
    assign rx_crc   = {held1_reg, held0_reg};

    always_comb
    begin
        esc_pend_next = esc_pend_reg;
        inside_next   = inside_reg;
        crc_next      = crc_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (step)
        begin
            if (is_esc)
            begin
                if (inside_reg)
                    esc_pend_next = 1'b1;
            end
            else if (is_start)
            begin
                inside_next   = 1'b1;
                esc_pend_next = 1'b0;
                crc_next      = efd_pkg::CRC_INIT;
                count_next    = 2'd0;
                len_next      = '0;
                ovf_next      = 1'b0;
            end
            else if (is_end)
            begin
                if (inside_reg)
                begin
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                    if (ovf_reg)
                        res.frame_status = efd_pkg::STATUS_OVERFLOW;
                    else if (count_reg < 2'd2)
                        res.frame_status = efd_pkg::STATUS_SHORT;
                    else if (rx_crc == crc_reg)
                        res.frame_status = efd_pkg::STATUS_GOOD;
                    else
                        res.frame_status = efd_pkg::STATUS_CRC_BAD;
                    // saturate length at 255
                    if (len_ext > EXT_W'(255))
                        res.payload_length = 8'd255;
                    else
                        res.payload_length = len_ext[7:0];
                    inside_next   = 1'b0;
                    esc_pend_next = 1'b0;
                end
            end
            else
            begin
                esc_pend_next = 1'b0;
                if (inside_reg && !ovf_reg)
                begin
                    if (fill >= (LEN_W+1)'(MAX_FRAME_LEN))
                        ovf_next = 1'b1;
                    else if (count_reg == 2'd0)
                    begin
                        held0_next = data;
                        count_next = 2'd1;
                    end
                    else if (count_reg == 2'd1)
                    begin
                        held1_next = data;
                        count_next = 2'd2;
                    end
                    else
                    begin
                        // release the oldest held byte into the CRC
                        res_valid        = 1'b1;
                        res.payload_byte = held0_reg;
                        crc_next         = efd_pkg::crc16_feed(crc_reg, held0_reg);
                        len_next         = len_reg + LEN_W'(1);
                        held0_next       = held1_reg;
                        held1_next       = data;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pend_reg <= 1'b0;
            inside_reg   <= 1'b0;
            crc_reg      <= efd_pkg::CRC_INIT;
            count_reg    <= 2'd0;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            esc_pend_reg <= esc_pend_next;
            inside_reg   <= inside_next;
            crc_reg      <= crc_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

endmodule

// ===== src/efd_out_stage.sv =====
module efd_out_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  efd_pkg::result_t              res,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [efd_pkg::BYTE_W-1:0]    payload_byte,
    output logic                          frame_end,
    output logic [efd_pkg::STATUS_W-1:0]  frame_status,
    output logic [efd_pkg::BYTE_W-1:0]    payload_length
);

    logic             valid_reg;
    logic             valid_next;
    efd_pkg::result_t res_reg;

    assign free           = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign payload_byte   = res_reg.payload_byte;
    assign frame_end      = res_reg.frame_end;
    assign frame_status   = res_reg.frame_status;
    assign payload_length = res_reg.payload_length;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// ===== bench/tb_escaped_frame_decoder_crc16_core.sv =====
`timescale 1ns / 1ps

module tb_escaped_frame_decoder_crc16_core;

    localparam int FRAME_LIMIT    = efd_pkg::MAX_FRAME_LEN_DEF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [efd_pkg::BYTE_W-1:0] octets_t[$];

    typedef enum
    {
        FRAME_CLEAN,
        FRAME_BAD_CRC,
        FRAME_CUT,
        FRAME_NOISY,
        FRAME_OPEN
    } frame_flaw_t;

    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            cfg_write      = 1'b0;
    logic [efd_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [efd_pkg::BYTE_W-1:0]      cfg_data       = '0;
    logic                            rx_valid       = 1'b0;
    logic                            rx_ready;
    logic [efd_pkg::BYTE_W-1:0]      rx_byte        = '0;
    logic                            out_valid;
    logic                            out_ready      = 1'b0;
    logic [efd_pkg::BYTE_W-1:0]      payload_byte;
    logic                            frame_end;
    logic [efd_pkg::STATUS_W-1:0]    frame_status;
    logic [efd_pkg::BYTE_W-1:0]      payload_length;

    // deframer mirror: delimiters and frame state
    efd_pkg::cfg_t              dec_cfg        = '{efd_pkg::START_BYTE_RST,
                                                   efd_pkg::END_BYTE_RST,
                                                   efd_pkg::ESCAPE_BYTE_RST};
    logic                       esc_armed      = 1'b0;
    logic                       in_frame       = 1'b0;
    logic [15:0]                crc_acc        = efd_pkg::CRC_INIT;
    logic [efd_pkg::BYTE_W-1:0] hold_q[2];
    int                         hold_cnt       = 0;
    int                         frame_len      = 0;
    logic                       frame_overflow = 1'b0;

    octets_t                    pending_bytes;
    efd_pkg::result_t           expected_results[$];
    efd_pkg::result_t           oldest_expected;
    int                         mismatches     = 0;
    int                         stalled_cycles = 0;
    int                         rx_gap         = 0;
    int                         rx_calm        = 0;
    int                         out_stall      = 0;
    int                         out_calm       = 0;

    escaped_frame_decoder_crc16_core
    #(
        .MAX_FRAME_LEN(FRAME_LIMIT)
    )
    DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .frame_end      (frame_end),
        .frame_status   (frame_status),
        .payload_length (payload_length)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] acc,
                                             input logic [efd_pkg::BYTE_W-1:0] octet);
        logic [15:0] r;
        r = acc ^ {8'h00, octet};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ efd_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int draw_gap(inout int calm_left);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (roll < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [efd_pkg::BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return dec_cfg.start_byte;
            1:       return dec_cfg.end_byte;
            2:       return dec_cfg.escape_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, wanted);
        mismatches++;
    endtask

    // advance the deframer mirror by one accepted byte
    task automatic track_rx_byte(input logic [efd_pkg::BYTE_W-1:0] b);
        logic             lit;
        efd_pkg::result_t res;
        lit = esc_armed;
        res = '0;
        if (!lit && b == dec_cfg.escape_byte)
        begin
            if (in_frame)
                esc_armed = 1'b1;
        end
        else if (!lit && b == dec_cfg.start_byte)
        begin
            in_frame       = 1'b1;
            esc_armed      = 1'b0;
            crc_acc        = efd_pkg::CRC_INIT;
            hold_cnt       = 0;
            frame_len      = 0;
            frame_overflow = 1'b0;
        end
        else if (!lit && b == dec_cfg.end_byte)
        begin
            if (in_frame)
            begin
                res.frame_end = 1'b1;
                if (frame_overflow)
                    res.frame_status = efd_pkg::STATUS_OVERFLOW;
                else if (hold_cnt < 2)
                    res.frame_status = efd_pkg::STATUS_SHORT;
                else if ({hold_q[1], hold_q[0]} == crc_acc)
                    res.frame_status = efd_pkg::STATUS_GOOD;
                else
                    res.frame_status = efd_pkg::STATUS_CRC_BAD;
                res.payload_length = (frame_len > 255) ? 8'hFF : 8'(frame_len);
                expected_results.push_back(res);
            end
            in_frame  = 1'b0;
            esc_armed = 1'b0;
        end
        else
        begin
            esc_armed = 1'b0;
            if (in_frame && !frame_overflow)
            begin
                if (frame_len + hold_cnt >= FRAME_LIMIT)
                    frame_overflow = 1'b1;
                else if (hold_cnt < 2)
                begin
                    hold_q[hold_cnt] = b;
                    hold_cnt++;
                end
                else
                begin
                    // release the oldest held byte into the CRC
                    res.payload_byte = hold_q[0];
                    crc_acc          = crc_step(crc_acc, hold_q[0]);
                    frame_len++;
                    hold_q[0]        = hold_q[1];
                    hold_q[1]        = b;
                    expected_results.push_back(res);
                end
            end
        end
    endtask

    // queue one frame under the current delimiters, stuffing special bytes
    task automatic push_frame(input octets_t payload, input frame_flaw_t flaw);
        logic [15:0]                sum;
        octets_t                    body;
        logic [efd_pkg::BYTE_W-1:0] b;
        sum = efd_pkg::CRC_INIT;
        foreach (payload[i])
            sum = crc_step(sum, payload[i]);
        if (flaw == FRAME_BAD_CRC)
            sum = sum ^ 16'($urandom_range(1, 65535));
        body = payload;
        body.push_back(sum[7:0]);
        body.push_back(sum[15:8]);
        if (flaw == FRAME_CUT)
            repeat ($urandom_range(1, 2))
                body.delete(body.size() - 1);
        pending_bytes.push_back(dec_cfg.start_byte);
        foreach (body[i])
        begin
            if (flaw == FRAME_NOISY && $urandom_range(0, 5) == 0)
                pending_bytes.push_back(noise_byte());
            b = body[i];
            if (b == dec_cfg.start_byte || b == dec_cfg.end_byte ||
                b == dec_cfg.escape_byte || $urandom_range(0, 15) == 0)
                pending_bytes.push_back(dec_cfg.escape_byte);
            pending_bytes.push_back(b);
        end
        if (flaw != FRAME_OPEN)
            pending_bytes.push_back(dec_cfg.end_byte);
    endtask

    task automatic fill_random(input int target);
        octets_t     body;
        frame_flaw_t flaw;
        int          added;
        int          mark;
        int          roll;
        int          len;
        added = 0;
        while (added < target)
        begin
            mark = pending_bytes.size();
            if ($urandom_range(0, 99) < 12)
                repeat ($urandom_range(1, 3))
                    pending_bytes.push_back(noise_byte());
            roll = $urandom_range(0, 99);
            if (roll < 10)
                len = $urandom_range(0, 1);
            else if (roll < 85)
                len = $urandom_range(2, 16);
            else
                len = $urandom_range(17, 60);
            body.delete();
            repeat (len)
                body.push_back(8'($urandom));
            roll = $urandom_range(0, 99);
            if (roll < 65)
                flaw = FRAME_CLEAN;
            else if (roll < 77)
                flaw = FRAME_BAD_CRC;
            else if (roll < 85)
                flaw = FRAME_CUT;
            else if (roll < 93)
                flaw = FRAME_NOISY;
            else
                flaw = FRAME_OPEN;
            push_frame(body, flaw);
            added += pending_bytes.size() - mark;
        end
    endtask

    // wait until every request is in and every result is out, then let the pipe drain
    task automatic settle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || rx_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [efd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [efd_pkg::BYTE_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            efd_pkg::REG_START_BYTE:  dec_cfg.start_byte  = val;
            efd_pkg::REG_END_BYTE:    dec_cfg.end_byte    = val;
            efd_pkg::REG_ESCAPE_BYTE: dec_cfg.escape_byte = val;
            default:                  ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_config(input logic [efd_pkg::BYTE_W-1:0] start_val,
                                input logic [efd_pkg::BYTE_W-1:0] end_val,
                                input logic [efd_pkg::BYTE_W-1:0] escape_val);
        write_reg(efd_pkg::REG_START_BYTE, start_val);
        write_reg(efd_pkg::REG_END_BYTE, end_val);
        write_reg(efd_pkg::REG_ESCAPE_BYTE, escape_val);
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= '0;
            rx_gap = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
                track_rx_byte(rx_byte);
            if (!rx_valid || rx_ready)
            begin
                if (rx_gap > 0 || pending_bytes.size() == 0)
                begin
                    rx_valid <= 1'b0;
                    if (rx_gap > 0)
                        rx_gap--;
                end
                else
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= pending_bytes.pop_front();
                    rx_gap = draw_gap(rx_calm);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected",
                                    int'({frame_end, payload_byte}), 0);
                else
                begin
                    oldest_expected = expected_results.pop_front();
                    if (payload_byte !== oldest_expected.payload_byte)
                        report_mismatch("payload_byte", int'(payload_byte),
                                        int'(oldest_expected.payload_byte));
                    if (frame_end !== oldest_expected.frame_end)
                        report_mismatch("frame_end", int'(frame_end),
                                        int'(oldest_expected.frame_end));
                    if (frame_status !== oldest_expected.frame_status)
                        report_mismatch("frame_status", int'(frame_status),
                                        int'(oldest_expected.frame_status));
                    if (payload_length !== oldest_expected.payload_length)
                        report_mismatch("payload_length", int'(payload_length),
                                        int'(oldest_expected.payload_length));
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall = draw_gap(out_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rx_valid && rx_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        octets_t                    body;
        logic [efd_pkg::BYTE_W-1:0] s_val;
        logic [efd_pkg::BYTE_W-1:0] e_val;
        logic [efd_pkg::BYTE_W-1:0] x_val;

        // outside a frame: drop data, drop end, ignore escape; then empty and one-byte frames
        pending_bytes = '{8'h00, 8'hFF, efd_pkg::END_BYTE_RST, efd_pkg::ESCAPE_BYTE_RST,
                          efd_pkg::START_BYTE_RST, efd_pkg::END_BYTE_RST,
                          efd_pkg::START_BYTE_RST, 8'hA5, efd_pkg::END_BYTE_RST};
        // restart inside a frame, then a frame with escaped delimiters and extremes
        pending_bytes.push_back(efd_pkg::START_BYTE_RST);
        pending_bytes.push_back(8'h33);
        body = '{8'h00, 8'hFF, efd_pkg::END_BYTE_RST, efd_pkg::ESCAPE_BYTE_RST,
                 efd_pkg::START_BYTE_RST};
        push_frame(body, FRAME_CLEAN);
        body = '{8'h7F};
        push_frame(body, FRAME_BAD_CRC);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_random(330);

        settle();
        apply_config(8'h00, 8'hFF, 8'h80);
        fill_random(400);

        // escape shadows start: nothing can open
        settle();
        apply_config(8'hFF, 8'h00, 8'hFF);
        fill_random(40);

        // start shadows end: frames only restart
        settle();
        apply_config(8'h7E, 8'h7E, 8'h7D);
        fill_random(60);

        // escape shadows end: frames never close
        settle();
        apply_config(8'hC0, 8'hC1, 8'hC1);
        fill_random(60);

        // longest frame that fits, then one byte too many
        settle();
        apply_config(8'h55, 8'hAA, 8'h00);
        body.delete();
        repeat (FRAME_LIMIT - 2)
            body.push_back(8'($urandom));
        push_frame(body, FRAME_CLEAN);
        body.push_back(8'($urandom));
        push_frame(body, FRAME_CLEAN);
        fill_random(150);

        settle();
        s_val = 8'($urandom);
        do
            e_val = 8'($urandom);
        while (e_val == s_val);
        do
            x_val = 8'($urandom);
        while (x_val == s_val || x_val == e_val);
        apply_config(s_val, e_val, x_val);
        fill_random(180);

        settle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
